/* sv/hpp_pkg.sv */
// Shared types and constants for the H.261 picture header parser.
`timescale 1ns / 1ps

package hpp_pkg;

    // Bits collected after the start-code '1': four skipped, nine kept.
    localparam int HDR_BITS  = 13;
    localparam int INFO_W    = 9;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int SHIFT_W   = 3;
    // Largest bit count for which a whole byte still fits in the header.
    localparam int FULL_MAX  = HDR_BITS - BYTE_W;
    localparam int TR_W      = 5;
    localparam int TDATA_W   = 16;

    typedef enum logic {
        PH_SEARCH  = 1'b0,
        PH_COLLECT = 1'b1
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic [TR_W-1:0] temporal_ref;
        logic            split_screen;
        logic            document_camera;
        logic            freeze_release;
        logic            is_cif;
        logic            status;
    } t_result;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_EOB = 1'b1;

endpackage

/* sv/h261_picture_header_parser.sv */
// Top level of the H.261 picture header parser: stream ports and result register.
`timescale 1ns / 1ps

// Byte-stream H.261 picture header parser. Bytes enter on the s_axis side one
// word per cycle, MSB first, with s_axis_tlast marking the last byte of the
// frame buffer. Zero bytes are skipped; the top set bit of the first nonzero
// byte is taken as the final '1' of the picture start code. The following 13
// bits are gathered, the first four dropped and the last nine reported as the
// temporal reference and the four picture-type flags, with tuser = 0. If the
// buffer ends before a header is complete, one word with tuser = 1 and all
// tdata bits zero is sent instead. Bits of the completing byte past the header
// are dropped and the parser goes back to searching. Throughput is one byte
// per clock: the start-bit priority encode and the byte shift sit in a single
// stage between the input register and the result register, so a result word
// is loaded into the result register as the parser takes its completing byte.
// Input is held off only while the result register is full and not being
// drained.
module h261_picture_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] temporal_ref, [5] split_screen,
                                        // [6] document_camera, [7] freeze_release,
                                        // [8] is_cif, [15:9] zero
    output logic [0:0]  m_axis_tuser    // [0] status: 0 parsed, 1 buffer ended
);

    hpp_pkg::t_in_word w_in_word;
    hpp_pkg::t_in_word w_st_word;
    logic              w_st_valid;
    logic              w_advance;
    logic              w_res_valid;
    hpp_pkg::t_result  w_res;
    logic              w_out_free;

    // Result register
    logic              r_out_valid;
    hpp_pkg::t_result  r_out;

    assign w_in_word.data_byte     = s_axis_tdata;
    assign w_in_word.end_of_buffer = s_axis_tlast;

    hpp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_word    (w_in_word),
        .i_advance (w_advance),
        .o_ready   (s_axis_tready),
        .o_valid   (w_st_valid),
        .o_word    (w_st_word)
    );

    // Result register free once empty or being taken this cycle.
    assign w_out_free = !r_out_valid || m_axis_tready;

    hpp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_st_valid),
        .i_word      (w_st_word),
        .i_out_free  (w_out_free),
        .o_advance   (w_advance),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out.is_cif, r_out.freeze_release,
                            r_out.document_camera, r_out.split_screen,
                            r_out.temporal_ref};
    assign m_axis_tuser  = r_out.status;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> m_axis_tvalid)
        else $error("produced result not presented");

    a_eob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '0)
        else $error("buffer-end word carries header bits");

endmodule

/* sv/hpp_in_stage.sv */
// Input register stage: holds one stream word until the parser takes it.
`timescale 1ns / 1ps

module hpp_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hpp_pkg::t_in_word i_word,
    input  logic             i_advance,
    output logic             o_ready,
    output logic             o_valid,
    output hpp_pkg::t_in_word o_word
);

    logic              r_valid;
    hpp_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

/* sv/hpp_parser.sv */
// Start-bit search and header bit collection, one byte per cycle while no result waits on a full output register.
`timescale 1ns / 1ps

module hpp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hpp_pkg::t_in_word i_word,
    input  logic              i_out_free,
    output logic              o_advance,
    output logic              o_res_valid,
    output hpp_pkg::t_result  o_res
);

    hpp_pkg::t_phase                   r_phase, n_phase;
    logic [hpp_pkg::INFO_W-1:0]        r_buf, n_buf;
    logic [hpp_pkg::CNT_W-1:0]         r_cnt, n_cnt;

    logic                              w_produce;
    logic [hpp_pkg::SHIFT_W-1:0]       w_pos;
    logic [hpp_pkg::BYTE_W-1:0]        w_low;
    logic [hpp_pkg::SHIFT_W-1:0]       w_sh;
    logic [hpp_pkg::CNT_W-1:0]         w_cnt_next;
    logic [hpp_pkg::INFO_W+hpp_pkg::BYTE_W-1:0] w_cat;
    logic [hpp_pkg::INFO_W-1:0]        w_buf_next;

    // Priority encode: position of the top set bit, and the bits below it.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < hpp_pkg::BYTE_W; i++) begin
            if (i_word.data_byte[i]) begin
                w_pos = hpp_pkg::SHIFT_W'(i);
            end
        end
        for (int i = 0; i < hpp_pkg::BYTE_W; i++) begin
            w_low[i] = i_word.data_byte[i] && (hpp_pkg::SHIFT_W'(i) < w_pos);
        end
    end

    // Collect step: whole byte while it fits, else only the bits still needed.
    always_comb begin
        if (r_cnt > hpp_pkg::CNT_W'(hpp_pkg::FULL_MAX)) begin
            w_sh       = hpp_pkg::SHIFT_W'(r_cnt - hpp_pkg::CNT_W'(hpp_pkg::FULL_MAX));
            w_cnt_next = hpp_pkg::CNT_W'(hpp_pkg::HDR_BITS);
        end else begin
            w_sh       = '0;
            w_cnt_next = r_cnt + hpp_pkg::CNT_W'(hpp_pkg::BYTE_W);
        end
        w_cat      = {r_buf, i_word.data_byte} >> w_sh;
        w_buf_next = w_cat[hpp_pkg::INFO_W-1:0];
    end

    always_comb begin
        n_phase   = r_phase;
        n_buf     = r_buf;
        n_cnt     = r_cnt;
        w_produce = 1'b0;
        o_res     = '0;
        o_res.status = hpp_pkg::STAT_EOB;
        case (r_phase)
            hpp_pkg::PH_SEARCH: begin
                if (i_word.end_of_buffer) begin
                    w_produce = 1'b1;
                end else if (i_word.data_byte != '0) begin
                    n_phase = hpp_pkg::PH_COLLECT;
                    n_buf   = hpp_pkg::INFO_W'(w_low);
                    n_cnt   = hpp_pkg::CNT_W'(w_pos);
                end
            end
            hpp_pkg::PH_COLLECT: begin
                if (w_cnt_next == hpp_pkg::CNT_W'(hpp_pkg::HDR_BITS)) begin
                    w_produce             = 1'b1;
                    o_res.temporal_ref    = w_buf_next[8:4];
                    o_res.split_screen    = w_buf_next[3];
                    o_res.document_camera = w_buf_next[2];
                    o_res.freeze_release  = w_buf_next[1];
                    o_res.is_cif          = w_buf_next[0];
                    o_res.status          = hpp_pkg::STAT_OK;
                    n_phase = hpp_pkg::PH_SEARCH;
                    n_buf   = '0;
                    n_cnt   = '0;
                end else if (i_word.end_of_buffer) begin
                    w_produce = 1'b1;
                    n_phase   = hpp_pkg::PH_SEARCH;
                    n_buf     = '0;
                    n_cnt     = '0;
                end else begin
                    n_buf = w_buf_next;
                    n_cnt = w_cnt_next;
                end
            end
            default: begin
                n_phase = hpp_pkg::PH_SEARCH;
                n_buf   = '0;
                n_cnt   = '0;
            end
        endcase
    end

    // A word that yields nothing moves on even while the result register is full.
    assign o_advance   = i_valid && (i_out_free || !w_produce);
    assign o_res_valid = o_advance && w_produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hpp_pkg::PH_SEARCH;
            r_buf   <= '0;
            r_cnt   <= '0;
        end else if (o_advance) begin
            r_phase <= n_phase;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
        end
    end

    a_search_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hpp_pkg::PH_SEARCH |-> (r_cnt == '0 && r_buf == '0))
        else $error("search phase with bits held");

    a_collect_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hpp_pkg::PH_COLLECT |-> r_cnt < hpp_pkg::CNT_W'(hpp_pkg::HDR_BITS))
        else $error("collect phase holding a complete header");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free)
        else $error("result produced into a full output register");

endmodule
